// ----- rtl/fade_timer_pool_assert.svh -----
// Assertion macros shared by the fade timer pool RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef FADE_TIMER_POOL_ASSERT_SVH
`define FADE_TIMER_POOL_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FTP_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fade timer pool: same-cycle check failed");
// next-cycle implication
`define FTP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fade timer pool: next-cycle check failed");
`else
`define FTP_ASSERT_NOW(name, ante, cons)
`define FTP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/ftp_pkg.sv -----
// Shared types and constants of the fade timer pool.
// No dependencies.
package ftp_pkg;

   localparam int DUR_W     = 24;
   localparam int ELAPSED_W = 16;
   localparam int ALPHA_W   = 8;
   localparam int MAX_RESULTS = 16;

   // request function codes
   localparam logic [2:0] FUNC_START   = 3'd0;
   localparam logic [2:0] FUNC_TICK    = 3'd1;
   localparam logic [2:0] FUNC_REL_ONE = 3'd2;
   localparam logic [2:0] FUNC_REL_ALL = 3'd3;
   localparam logic [2:0] FUNC_REPORT  = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // which response beat to build
   typedef enum logic [2:0] {
      PUSH_OK,
      PUSH_CLAIM,
      PUSH_FULL,
      PUSH_PEND_MORE,
      PUSH_PEND_LAST,
      PUSH_NONE
   } push_kind_type;

   typedef struct packed {
      logic          load;
      logic          step;
      logic          claim;
      logic          tick_upd;
      logic          release_one;
      logic          release_all;
      logic          div_start;
      logic          stash;
      logic          push;
      push_kind_type kind;
   } ftp_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       n_zero;
      logic       idx_last;
      logic       slot_active;
      logic       div_done;
      logic       out_free;
      logic       pend_valid;
      logic       k_last;
   } ftp_status_type;

endpackage

// ----- rtl/ftp_alpha_div.sv -----
// Serial divider for alpha = floor(255 * remaining / total), inverted unless fade_out, one bit per cycle.
// Depends on ftp_pkg.
module ftp_alpha_div
   import ftp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DUR_W-1:0]     remaining,
   input  logic [DUR_W-1:0]     total,
   input  logic                 fade_out,
   output logic                 done,
   output logic [ALPHA_W-1:0]   alpha
);

   localparam int NUM_W = DUR_W + ALPHA_W;

   logic                busy_ff;
   logic [3:0]          step_ff;
   logic                done_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [NUM_W-1:0]    den_ff;
   logic [ALPHA_W-1:0]  q_ff;
   logic                sat_ff;
   logic                zero_ff;
   logic                fo_ff;
   logic                ge;
   logic [ALPHA_W-1:0]  q_eff;

   assign ge = num_ff >= den_ff;

   // control: step 0 checks saturation, steps 1..8 produce quotient bits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == 4'(ALPHA_W));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == 4'(ALPHA_W)) begin
               busy_ff <= 1'b0;
            end
            step_ff <= step_ff + 4'd1;
         end
      end
   end

   // datapath: 255*rem = (rem << 8) - rem
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= {remaining, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, remaining};
         den_ff  <= {total, {ALPHA_W{1'b0}}};
         q_ff    <= '0;
         sat_ff  <= 1'b0;
         zero_ff <= (total == '0);
         fo_ff   <= fade_out;
      end else if (busy_ff) begin
         den_ff <= den_ff >> 1;
         if (step_ff == 4'd0) begin
            sat_ff <= ge;
         end else begin
            if (ge) begin
               num_ff <= num_ff - den_ff;
            end
            q_ff <= {q_ff[ALPHA_W-2:0], ge};
         end
      end
   end

   always_comb begin
      if (zero_ff) begin
         q_eff = '0;
      end else if (sat_ff) begin
         q_eff = '1;
      end else begin
         q_eff = q_ff;
      end
   end

   assign alpha = fo_ff ? q_eff : ~q_eff;
   assign done  = done_ff;

endmodule

// ----- rtl/ftp_datapath.sv -----
// Datapath of the fade timer pool: slot store, active flags, result staging.
// Depends on ftp_pkg, ftp_alpha_div and fade_timer_pool_assert.svh.
`include "fade_timer_pool_assert.svh"
module ftp_datapath
   import ftp_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ftp_cmd_type           cmd,
   output ftp_status_type        status,
   input  logic [2:0]            req_func,
   input  logic [DUR_W-1:0]      req_duration_ms,
   input  logic                  req_fade_out,
   input  logic [ELAPSED_W-1:0]  req_elapsed_ms,
   input  logic [3:0]            req_slot_select,
   input  logic                  csr_write,
   input  logic [4:0]            csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [3:0]            rsp_slot_index,
   output logic [ALPHA_W-1:0]    rsp_alpha,
   output logic                  rsp_any_active,
   output logic                  rsp_last
);

   localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW     = $clog2(SLOTS + 1);
   localparam int EW     = (NW > 5) ? NW : 5;
   localparam int WORD_W = 2 * DUR_W + 2;

   // latched request
   logic [2:0]            func_ff;
   logic [DUR_W-1:0]      dur_ff;
   logic                  fo_ff;
   logic [ELAPSED_W-1:0]  el_ff;

   logic [SW-1:0]         idx_ff;
   logic [EW-1:0]         n_ff;
   logic [EW-1:0]         n_in;
   logic [SLOTS-1:0]      active_ff;
   logic [SLOTS-1:0]      active_in;
   logic [NW-1:0]         cnt_ff;
   logic [NW-1:0]         cnt_in;
   logic [3:0]            k_ff;

   // slot store word: {expired, fade_out, total, remaining}
   logic [WORD_W-1:0]     mem [SLOTS];
   logic [WORD_W-1:0]     rd_ff;
   logic                  mem_we;
   logic [WORD_W-1:0]     mem_wdata;

   logic [DUR_W-1:0]      rd_rem;
   logic [DUR_W-1:0]      rd_tot;
   logic                  rd_fo;
   logic                  rd_exp;
   logic [DUR_W-1:0]      tick_rem;
   logic                  tick_exp;
   logic                  tick_free;
   logic                  tick_live;

   logic [SW-1:0]         sel_idx;
   logic                  sel_ok;

   logic                  pend_valid_ff;
   logic [3:0]            pend_idx_ff;
   logic [ALPHA_W-1:0]    pend_alpha_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [3:0]            rsp_slot_index_ff;
   logic [ALPHA_W-1:0]    rsp_alpha_ff;
   logic                  rsp_any_ff;
   logic                  rsp_last_ff;
   logic                  out_free;

   logic                  div_done;
   logic [ALPHA_W-1:0]    div_alpha;

   assign rd_rem = rd_ff[DUR_W-1:0];
   assign rd_tot = rd_ff[2*DUR_W-1:DUR_W];
   assign rd_fo  = rd_ff[2*DUR_W];
   assign rd_exp = rd_ff[2*DUR_W+1];

   // tick update of the slot under the scan index
   assign tick_live = cmd.tick_upd && active_ff[idx_ff];
   assign tick_rem  = (DUR_W'(el_ff) > rd_rem) ? '0 : rd_rem - DUR_W'(el_ff);
   assign tick_exp  = rd_exp || (rd_rem == '0);
   assign tick_free = (rd_rem == '0) && rd_exp;

   // single-slot release check
   assign sel_idx = SW'(req_slot_select);
   assign sel_ok  = (EW'(req_slot_select) < n_ff) && active_ff[sel_idx];

   // slot store, read registered at the scan index
   assign mem_we    = cmd.claim || tick_live;
   assign mem_wdata = cmd.claim ? {1'b0, fo_ff, dur_ff, dur_ff}
                                : {tick_exp, rd_fo, rd_tot, tick_rem};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff];
   end

   // enabled count from the written register
   assign n_in = (EW'(csr_wdata) >= EW'(SLOTS)) ? EW'(SLOTS) : EW'(csr_wdata);

   // active flags and active count
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (cmd.claim) begin
         active_in[idx_ff] = 1'b1;
         cnt_in            = cnt_ff + NW'(1);
      end
      if (tick_live && tick_free) begin
         active_in[idx_ff] = 1'b0;
         cnt_in            = cnt_ff - NW'(1);
      end
      if (cmd.release_one && sel_ok) begin
         active_in[sel_idx] = 1'b0;
         cnt_in             = cnt_ff - NW'(1);
      end
      if (cmd.release_all) begin
         active_in = '0;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= '0;
         active_ff <= '0;
         cnt_ff    <= '0;
      end else if (csr_write) begin
         n_ff      <= n_in;
         active_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         dur_ff  <= req_duration_ms;
         fo_ff   <= req_fade_out;
         el_ff   <= req_elapsed_ms;
      end
   end

   // scan index, report counter and pending report beat
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            k_ff   <= '0;
         end else if (cmd.step) begin
            idx_ff <= idx_ff + SW'(1);
         end
         if (cmd.stash) begin
            pend_valid_ff <= 1'b1;
            k_ff          <= k_ff + 4'd1;
         end else if (cmd.push && cmd.kind == PUSH_PEND_LAST) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stash) begin
         pend_idx_ff   <= 4'(idx_ff);
         pend_alpha_ff <= div_alpha;
      end
   end

   ftp_alpha_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .remaining (rd_rem),
      .total     (rd_tot),
      .fade_out  (rd_fo),
      .done      (div_done),
      .alpha     (div_alpha)
   );

   // response register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_status_ff     <= STATUS_OK;
         rsp_slot_index_ff <= '0;
         rsp_alpha_ff      <= '0;
         rsp_any_ff        <= (cnt_ff != '0);
         rsp_last_ff       <= 1'b1;
         case (cmd.kind)
            PUSH_OK: begin
            end
            PUSH_CLAIM: begin
               rsp_slot_index_ff <= 4'(idx_ff);
               rsp_any_ff        <= 1'b1;
            end
            PUSH_FULL: begin
               rsp_status_ff <= STATUS_FULL;
            end
            PUSH_PEND_MORE: begin
               rsp_slot_index_ff <= pend_idx_ff;
               rsp_alpha_ff      <= pend_alpha_ff;
               rsp_any_ff        <= 1'b1;
               rsp_last_ff       <= 1'b0;
            end
            PUSH_PEND_LAST: begin
               rsp_slot_index_ff <= pend_idx_ff;
               rsp_alpha_ff      <= pend_alpha_ff;
               rsp_any_ff        <= 1'b1;
            end
            PUSH_NONE: begin
               rsp_status_ff <= STATUS_EMPTY;
               rsp_any_ff    <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_alpha      = rsp_alpha_ff;
   assign rsp_any_active = rsp_any_ff;
   assign rsp_last       = rsp_last_ff;

   // status toward the controller
   assign status.func        = func_ff;
   assign status.n_zero      = (n_ff == '0);
   assign status.idx_last    = ((EW'(idx_ff) + EW'(1)) == n_ff);
   assign status.slot_active = active_ff[idx_ff];
   assign status.div_done    = div_done;
   assign status.out_free    = out_free;
   assign status.pend_valid  = pend_valid_ff;
   assign status.k_last      = (k_ff == 4'(MAX_RESULTS - 1));

   // checks
   `FTP_ASSERT_NOW(a_cnt_bound, 1'b1, EW'(cnt_ff) <= n_ff)
   `FTP_ASSERT_NOW(a_push_free, cmd.push, out_free)
   `FTP_ASSERT_NOW(a_stash_flush, cmd.stash && pend_valid_ff, cmd.push)
   `FTP_ASSERT_NOW(a_claim_free, cmd.claim, !active_ff[idx_ff])
   `FTP_ASSERT_NEXT(a_claim_count, cmd.claim && !csr_write, cnt_ff == $past(cnt_ff) + NW'(1))

endmodule

// ----- rtl/ftp_ctrl.sv -----
// Controller of the fade timer pool: sequences slot scans, divides and result beats.
// Depends on ftp_pkg.
module ftp_ctrl
   import ftp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [2:0]      req_func,
   output logic            req_stall,
   input  ftp_status_type  status,
   output ftp_cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH,
      S_RD,
      S_EX,
      S_DIV,
      S_STASH,
      S_FINAL
   } state_type;

   state_type      state_ff;
   state_type      state_in;
   push_kind_type  kind_ff;
   push_kind_type  kind_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_FINAL;
               kind_in  = PUSH_OK;
               case (req_func)
                  FUNC_START: begin
                     if (status.n_zero) begin
                        kind_in = PUSH_FULL;
                     end else begin
                        state_in = S_SRCH;
                     end
                  end
                  FUNC_TICK: begin
                     if (!status.n_zero) begin
                        state_in = S_RD;
                     end
                  end
                  FUNC_REL_ONE: begin
                     cmd.release_one = 1'b1;
                  end
                  FUNC_REL_ALL: begin
                     cmd.release_all = 1'b1;
                  end
                  FUNC_REPORT: begin
                     if (status.n_zero) begin
                        kind_in = PUSH_NONE;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // start: look for the lowest free slot
         S_SRCH: begin
            if (!status.slot_active) begin
               cmd.claim = 1'b1;
               kind_in   = PUSH_CLAIM;
               state_in  = S_FINAL;
            end else if (status.idx_last) begin
               kind_in  = PUSH_FULL;
               state_in = S_FINAL;
            end else begin
               cmd.step = 1'b1;
            end
         end
         // store read in flight
         S_RD: begin
            state_in = S_EX;
         end
         S_EX: begin
            if (status.func == FUNC_TICK) begin
               cmd.tick_upd = 1'b1;
               if (status.idx_last) begin
                  kind_in  = PUSH_OK;
                  state_in = S_FINAL;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_RD;
               end
            end else if (status.slot_active) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.idx_last) begin
               kind_in  = status.pend_valid ? PUSH_PEND_LAST : PUSH_NONE;
               state_in = S_FINAL;
            end else begin
               cmd.step = 1'b1;
               state_in = S_RD;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_STASH;
            end
         end
         // flush the older report beat while holding the new one
         S_STASH: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.stash = 1'b1;
               cmd.push  = status.pend_valid;
               cmd.kind  = PUSH_PEND_MORE;
               if (status.idx_last || status.k_last) begin
                  kind_in  = PUSH_PEND_LAST;
                  state_in = S_FINAL;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= PUSH_OK;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ----- rtl/fade_timer_pool.sv -----
// Top level of the fade timer pool: controller plus datapath.
// Depends on ftp_pkg, ftp_ctrl, ftp_datapath.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    func, duration_ms, fade_out, elapsed_ms, slot_select
//   rsp      out  rsp_valid/stall    status, slot_index, alpha, any_active, last
//   csr      in   csr_write          csr_wdata (slots_in_use)
//
// One request at a time; N = enabled slots. Start: a free-slot scan over up to N slots.
// Tick: a read then an update per slot through the store's read port.
// Report: a read per slot, and for each active slot an alpha from the 9-step serial
// divider. Release and unknown codes answer without a scan. Response stalls only
// hold the final or pending beat; reset is synchronous and clears every slot's active flag, no clearing pass.
module fade_timer_pool
   import ftp_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_func,
   input  logic [DUR_W-1:0]      req_duration_ms,
   input  logic                  req_fade_out,
   input  logic [ELAPSED_W-1:0]  req_elapsed_ms,
   input  logic [3:0]            req_slot_select,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [3:0]            rsp_slot_index,
   output logic [ALPHA_W-1:0]    rsp_alpha,
   output logic                  rsp_any_active,
   output logic                  rsp_last,
   input  logic                  csr_write,
   input  logic [4:0]            csr_wdata
);

   ftp_cmd_type     cmd;
   ftp_status_type  status;

   ftp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ftp_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_duration_ms (req_duration_ms),
      .req_fade_out    (req_fade_out),
      .req_elapsed_ms  (req_elapsed_ms),
      .req_slot_select (req_slot_select),
      .csr_write       (csr_write),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_alpha       (rsp_alpha),
      .rsp_any_active  (rsp_any_active),
      .rsp_last        (rsp_last)
   );

endmodule
